FILE: rtl/hbs_pkg.sv
`timescale 1ns / 1ps

package hbs_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int INV_W       = 24;
  localparam int EXT_W       = 8;
  localparam int GRID_SIDE   = 128;
  localparam int IDX_W       = $clog2(GRID_SIDE);
  localparam int HALF_W      = IDX_W - 1;
  localparam int BANK_ADDR_W = 2 * HALF_W;
  localparam int BANK_DEPTH  = 2 ** BANK_ADDR_W;
  localparam int NUM_BANKS   = 4;
  localparam int BANK_SEL_W  = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int DIFF_W      = WORD_W + 1;
  localparam int PROD_W      = WORD_W + INV_W;
  localparam int SHIFT       = WORD_W - FRAC_W;
  localparam int G_W         = PROD_W - SHIFT;
  localparam int GRID_W      = IDX_W + FRAC_W;
  localparam int LERP_DEPTH  = 3;
  localparam int TAG_DEPTH   = 2 * LERP_DEPTH + 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X        = 3'd0,
    REG_ORIGIN_Z        = 3'd1,
    REG_INVERSE_SPACING = 3'd2,
    REG_GRID_COLUMNS    = 3'd3,
    REG_GRID_ROWS       = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Grid position of one axis after clamping, with bank addresses.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [HALF_W-1:0] addr_even;
    logic [HALF_W-1:0] addr_odd;
    logic [FRAC_W-1:0] frac;
    logic              clamp;
  } axis_t;

  typedef struct packed {
    logic query;
    logic loaded;
  } tag_t;

endpackage

FILE: rtl/hbs_axis.sv
`timescale 1ns / 1ps

module hbs_axis (
  input  logic                                clk,
  input  logic signed [hbs_pkg::WORD_W-1:0]   coord,
  input  logic signed [hbs_pkg::WORD_W-1:0]   origin,
  input  logic        [hbs_pkg::INV_W-1:0]    inv_spacing,
  input  logic        [hbs_pkg::EXT_W-1:0]    grid_size,
  output hbs_pkg::axis_t                      pos
);
  import hbs_pkg::*;

  // stage 1: offset from origin, negative side folds to zero
  logic [DIFF_W-1:0] diff;
  logic [WORD_W-1:0] dmag;

  assign diff = {coord[WORD_W-1], coord} - {origin[WORD_W-1], origin};

  always_ff @(posedge clk) begin
    dmag <= (!diff[DIFF_W-1] && (diff[WORD_W-1:0] != '0)) ? diff[WORD_W-1:0] : '0;
  end

  // stage 2: scale by reciprocal spacing
  logic [PROD_W-1:0] prod;
  logic [G_W-1:0]    g;

  assign prod = PROD_W'(dmag) * PROD_W'(inv_spacing);

  always_ff @(posedge clk) begin
    g <= prod[PROD_W-1:SHIFT];
  end

  // stage 3: clamp to last vertex, split into cell index and fraction
  logic [EXT_W-1:0]  size_m1;
  logic [IDX_W-1:0]  last;
  logic [GRID_W-1:0] top_g;
  logic [GRID_W-1:0] gc;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W:0]    idx_inc;

  assign size_m1 = grid_size - EXT_W'(1);

  always_comb begin
    if (grid_size == '0) begin
      last = '0;
    end else if (grid_size > EXT_W'(GRID_SIDE)) begin
      last = IDX_W'(GRID_SIDE - 1);
    end else begin
      last = size_m1[IDX_W-1:0];
    end
  end

  assign top_g   = {last, {FRAC_W{1'b0}}};
  assign gc      = (g > G_W'(top_g)) ? top_g : g[GRID_W-1:0];
  assign idx     = gc[GRID_W-1:FRAC_W];
  assign idx_inc = {1'b0, idx} + (IDX_W+1)'(1);

  always_ff @(posedge clk) begin
    pos.idx       <= idx;
    pos.addr_even <= idx_inc[IDX_W-1:1];
    pos.addr_odd  <= idx[IDX_W-1:1];
    pos.frac      <= gc[FRAC_W-1:0];
    pos.clamp     <= (idx == last);
  end

endmodule

FILE: rtl/hbs_bank.sv
`timescale 1ns / 1ps

module hbs_bank (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [hbs_pkg::BANK_ADDR_W-1:0]   wr_addr,
  input  logic [hbs_pkg::WORD_W-1:0]        wr_data,
  input  logic [hbs_pkg::BANK_ADDR_W-1:0]   rd_addr,
  output logic [hbs_pkg::WORD_W-1:0]        rd_data
);
  import hbs_pkg::*;

  logic [WORD_W-1:0] mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/hbs_lerp.sv
`timescale 1ns / 1ps

module hbs_lerp (
  input  logic                              clk,
  input  logic signed [hbs_pkg::WORD_W-1:0] a,
  input  logic signed [hbs_pkg::WORD_W-1:0] b,
  input  logic        [hbs_pkg::FRAC_W-1:0] frac,
  output logic signed [hbs_pkg::WORD_W-1:0] h
);
  import hbs_pkg::*;

  // h = a + floor((b - a) * f / 2^F)
  logic signed [DIFF_W-1:0]        diff;
  logic signed [WORD_W-1:0]        a_a;
  logic        [FRAC_W-1:0]        f_a;
  logic signed [DIFF_W+FRAC_W:0]   prod;
  logic signed [WORD_W-1:0]        a_b;

  always_ff @(posedge clk) begin
    diff <= {b[WORD_W-1], b} - {a[WORD_W-1], a};
    a_a  <= a;
    f_a  <= frac;
    prod <= (DIFF_W+FRAC_W+1)'(diff) * (DIFF_W+FRAC_W+1)'($signed({1'b0, f_a}));
    a_b  <= a_a;
    h    <= a_b + prod[FRAC_W+WORD_W-1:FRAC_W];
  end

endmodule

FILE: rtl/heightmap_bilinear_sampler_core.sv
`timescale 1ns / 1ps

// Heightmap bilinear sampler.
// Requests enter on start with opcode: a write request stores cell_height at
// (cell_column, cell_row); a query request samples the map at (query_x,
// query_z), all signed Q16.16. busy is always low, so a request is taken on
// every cycle that start is high: one request per clock, sustained.
// Query result: sampled_height with a one-cycle done strobe. Write requests give
// no result. Results come out in request order; the receiver cannot stall,
// so nothing is held back.
// Pipeline: offset, scale multiply, clamp/address, four-bank heightmap read
// (banked on column and row parity so all four neighbors are read together),
// then two x blends in parallel and a z blend, each a 3-stage multiply unit.
// Writes go through the same pipeline and land in the store at the read
// stage, so a query always sees every earlier write.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once; the user
// must make them only while no request is in flight, as the block does not enforce this.
// Reset clears the configuration to its defaults and marks the store empty;
// queries before the first write return zero. Store contents are not cleared.
module heightmap_bilinear_sampler_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   opcode,
  input  logic        [hbs_pkg::IDX_W-1:0]       cell_column,
  input  logic        [hbs_pkg::IDX_W-1:0]       cell_row,
  input  logic signed [hbs_pkg::WORD_W-1:0]      cell_height,
  input  logic signed [hbs_pkg::WORD_W-1:0]      query_x,
  input  logic signed [hbs_pkg::WORD_W-1:0]      query_z,
  output logic                                   done,
  output logic signed [hbs_pkg::WORD_W-1:0]      sampled_height,
  input  logic                                   cfg_write,
  input  logic        [hbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [hbs_pkg::WORD_W-1:0]      cfg_data
);
  import hbs_pkg::*;

  // ---------------- configuration ----------------
  logic signed [WORD_W-1:0] origin_x;
  logic signed [WORD_W-1:0] origin_z;
  logic        [INV_W-1:0]  inverse_spacing;
  logic        [EXT_W-1:0]  grid_columns;
  logic        [EXT_W-1:0]  grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= '0;
      origin_z        <= '0;
      inverse_spacing <= INV_W'(1 << FRAC_W);
      grid_columns    <= EXT_W'(GRID_SIDE);
      grid_rows       <= EXT_W'(GRID_SIDE);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_X:        origin_x        <= cfg_data;
        REG_ORIGIN_Z:        origin_z        <= cfg_data;
        REG_INVERSE_SPACING: inverse_spacing <= cfg_data[INV_W-1:0];
        REG_GRID_COLUMNS:    grid_columns    <= cfg_data[EXT_W-1:0];
        REG_GRID_ROWS:       grid_rows       <= cfg_data[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // never stalls: one request per clock
  assign busy = 1'b0;

  // ---------------- stages 1-3: request control and write payload ----------------
  logic              accept;
  logic              s1_valid, s2_valid, s3_valid;
  op_t               s1_op, s2_op, s3_op;
  logic [IDX_W-1:0]  s1_col, s2_col, s3_col;
  logic [IDX_W-1:0]  s1_row, s2_row, s3_row;
  logic [WORD_W-1:0] s1_height, s2_height, s3_height;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s1_op     <= op_t'(opcode);
    s1_col    <= cell_column;
    s1_row    <= cell_row;
    s1_height <= cell_height;
    s2_op     <= s1_op;
    s2_col    <= s1_col;
    s2_row    <= s1_row;
    s2_height <= s1_height;
    s3_op     <= s2_op;
    s3_col    <= s2_col;
    s3_row    <= s2_row;
    s3_height <= s2_height;
  end

  // coordinate pipes (3 stages each), aligned with s3
  axis_t pos_x, pos_z;

  hbs_axis u_axis_x (
    .clk         (clk),
    .coord       (query_x),
    .origin      (origin_x),
    .inv_spacing (inverse_spacing),
    .grid_size   (grid_columns),
    .pos         (pos_x)
  );

  hbs_axis u_axis_z (
    .clk         (clk),
    .coord       (query_z),
    .origin      (origin_z),
    .inv_spacing (inverse_spacing),
    .grid_size   (grid_rows),
    .pos         (pos_z)
  );

  // ---------------- stage 4: banked store ----------------
  // bank index = {row parity, column parity}; address = {row>>1, col>>1}.
  // The even-side bank of an axis holds ix0 or ix0+1, whichever is even.
  logic                   wr_go;
  logic                   loaded;
  logic [WORD_W-1:0]      bank_q [NUM_BANKS];

  assign wr_go = s3_valid && (s3_op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
    end else if (wr_go) begin
      loaded <= 1'b1;
    end
  end

  for (genvar bk = 0; bk < NUM_BANKS; bk++) begin : g_bank
    logic                   bank_we;
    logic [BANK_ADDR_W-1:0] bank_ra;

    assign bank_we = wr_go && ({s3_row[0], s3_col[0]} == BANK_SEL_W'(bk));
    assign bank_ra = {(bk / 2 == 1) ? pos_z.addr_odd : pos_z.addr_even,
                      (bk % 2 == 1) ? pos_x.addr_odd : pos_x.addr_even};

    hbs_bank u_bank (
      .clk     (clk),
      .wr_en   (bank_we),
      .wr_addr ({s3_row[IDX_W-1:1], s3_col[IDX_W-1:1]}),
      .wr_data (s3_height),
      .rd_addr (bank_ra),
      .rd_data (bank_q[bk])
    );
  end

  // side info that travels with the read
  logic              s4_x_lsb, s4_z_lsb;
  logic              s4_x_clamp, s4_z_clamp;
  logic [FRAC_W-1:0] s4_fx, s4_fz;
  tag_t              tag_pipe [TAG_DEPTH];
  logic [FRAC_W-1:0] fz_pipe  [LERP_DEPTH];

  always_ff @(posedge clk) begin
    s4_x_lsb   <= pos_x.idx[0];
    s4_z_lsb   <= pos_z.idx[0];
    s4_x_clamp <= pos_x.clamp;
    s4_z_clamp <= pos_z.clamp;
    s4_fx      <= pos_x.frac;
    s4_fz      <= pos_z.frac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAG_DEPTH; i++) begin
        tag_pipe[i] <= '0;
      end
    end else begin
      tag_pipe[0] <= '{query: s3_valid && (s3_op == OP_QUERY), loaded: loaded};
      for (int i = 1; i < TAG_DEPTH; i++) begin
        tag_pipe[i] <= tag_pipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    fz_pipe[0] <= s4_fz;
    for (int i = 1; i < LERP_DEPTH; i++) begin
      fz_pipe[i] <= fz_pipe[i-1];
    end
  end

  // ---------------- neighbor selection ----------------
  // At the far edge the fraction is zero and the second neighbor is the first.
  logic                     z1_lsb;
  logic signed [WORD_W-1:0] c00, c10, c01, c11;

  assign z1_lsb = s4_z_clamp ? s4_z_lsb : !s4_z_lsb;

  always_comb begin
    c00 = bank_q[{s4_z_lsb, s4_x_lsb}];
    c10 = s4_x_clamp ? c00 : bank_q[{s4_z_lsb, !s4_x_lsb}];
    c01 = bank_q[{z1_lsb, s4_x_lsb}];
    c11 = s4_x_clamp ? c01 : bank_q[{z1_lsb, !s4_x_lsb}];
  end

  // ---------------- blends: x on both rows, then z ----------------
  logic signed [WORD_W-1:0] h0, h1, hz;

  hbs_lerp u_lerp_x0 (
    .clk  (clk),
    .a    (c00),
    .b    (c10),
    .frac (s4_fx),
    .h    (h0)
  );

  hbs_lerp u_lerp_x1 (
    .clk  (clk),
    .a    (c01),
    .b    (c11),
    .frac (s4_fx),
    .h    (h1)
  );

  hbs_lerp u_lerp_z (
    .clk  (clk),
    .a    (h0),
    .b    (h1),
    .frac (fz_pipe[LERP_DEPTH-1]),
    .h    (hz)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_pipe[TAG_DEPTH-1].query;
    end
    sampled_height <= tag_pipe[TAG_DEPTH-1].loaded ? hz : '0;
  end

endmodule

FILE: tb/hbs_height_checker.sv
`timescale 1ns / 1ps

// Watches request, config and result ports of the heightmap sampler,
// keeps its own copy of the map and registers, and scores every result.
module hbs_height_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic                                   opcode,
  input  logic        [hbs_pkg::IDX_W-1:0]       cell_column,
  input  logic        [hbs_pkg::IDX_W-1:0]       cell_row,
  input  logic signed [hbs_pkg::WORD_W-1:0]      cell_height,
  input  logic signed [hbs_pkg::WORD_W-1:0]      query_x,
  input  logic signed [hbs_pkg::WORD_W-1:0]      query_z,
  input  logic                                   done,
  input  logic signed [hbs_pkg::WORD_W-1:0]      sampled_height,
  input  logic                                   cfg_write,
  input  logic        [hbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [hbs_pkg::WORD_W-1:0]      cfg_data,
  output int                                     requests_taken,
  output int                                     queries_in_flight,
  output int                                     mismatch_count
);
  import hbs_pkg::*;

  logic signed [WORD_W-1:0] origin_x;
  logic signed [WORD_W-1:0] origin_z;
  logic        [INV_W-1:0]  inv_spacing;
  logic        [EXT_W-1:0]  columns_reg;
  logic        [EXT_W-1:0]  rows_reg;
  logic                     map_loaded;
  logic signed [WORD_W-1:0] height_map [GRID_SIDE*GRID_SIDE];
  logic signed [WORD_W-1:0] expected_heights [$];
  int                       queries_checked;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned grid_side(input logic [EXT_W-1:0] r);
    if (r == 0) return 1;
    if (r > GRID_SIDE) return GRID_SIDE;
    return 32'(r);
  endfunction

  // grid coordinate, FRAC_W fraction bits, clamped to [0, last vertex]
  function automatic longint unsigned grid_coord(input logic signed [WORD_W-1:0] pos,
                                                 input logic signed [WORD_W-1:0] org,
                                                 input int unsigned side);
    longint          offset;
    longint unsigned scaled;
    longint unsigned last;
    offset = longint'(pos) - longint'(org);
    last   = longint'(side - 1) << FRAC_W;
    scaled = 0;
    if (offset > 0) scaled = (offset * longint'(inv_spacing)) >> SHIFT;
    return (scaled > last) ? last : scaled;
  endfunction

  // exact blend, floor toward minus infinity
  function automatic longint lerp(input longint a, input longint b, input longint w);
    return (a * ((longint'(1) << FRAC_W) - w) + b * w) >>> FRAC_W;
  endfunction

  function automatic longint map_cell(input int unsigned col, input int unsigned row);
    return longint'(height_map[row * GRID_SIDE + col]);
  endfunction

  function automatic logic signed [WORD_W-1:0] predict_height(
      input logic signed [WORD_W-1:0] qx, input logic signed [WORD_W-1:0] qz);
    int unsigned     cols, rows, x0, x1, z0, z1;
    longint unsigned gx, gz;
    longint          near_row, far_row, blended;
    if (!map_loaded) return '0;
    cols = grid_side(columns_reg);
    rows = grid_side(rows_reg);
    gx   = grid_coord(qx, origin_x, cols);
    gz   = grid_coord(qz, origin_z, rows);
    x0   = 32'(gx >> FRAC_W);
    z0   = 32'(gz >> FRAC_W);
    x1   = (x0 + 1 < cols) ? x0 + 1 : cols - 1;
    z1   = (z0 + 1 < rows) ? z0 + 1 : rows - 1;
    near_row = lerp(map_cell(x0, z0), map_cell(x1, z0), longint'(gx[FRAC_W-1:0]));
    far_row  = lerp(map_cell(x0, z1), map_cell(x1, z1), longint'(gx[FRAC_W-1:0]));
    blended  = lerp(near_row, far_row, longint'(gz[FRAC_W-1:0]));
    return blended[WORD_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic signed [WORD_W-1:0] want;
    if (rst) begin
      origin_x    = '0;
      origin_z    = '0;
      inv_spacing = INV_W'(1 << FRAC_W);
      columns_reg = EXT_W'(GRID_SIDE);
      rows_reg    = EXT_W'(GRID_SIDE);
      map_loaded  = 1'b0;
      expected_heights.delete();
    end else begin
      if ($isunknown(done)) begin
        report_mismatch("done strobe is unknown");
      end else if (done) begin
        if (expected_heights.size() == 0) begin
          report_mismatch($sformatf("sampled_height %0d with no query waiting",
                                    sampled_height));
        end else begin
          want = expected_heights.pop_front();
          if (sampled_height !== want)
            report_mismatch($sformatf("query %0d: sampled_height %0d, expected %0d",
                                      queries_checked, sampled_height, want));
          queries_checked++;
        end
      end
      if (start && !busy) begin
        requests_taken++;
        if (op_t'(opcode) == OP_WRITE) begin
          height_map[{cell_row, cell_column}] = cell_height;
          map_loaded = 1'b1;
        end else begin
          expected_heights = {expected_heights, predict_height(query_x, query_z)};
        end
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_ORIGIN_X:        origin_x    = cfg_data;
          REG_ORIGIN_Z:        origin_z    = cfg_data;
          REG_INVERSE_SPACING: inv_spacing = cfg_data[INV_W-1:0];
          REG_GRID_COLUMNS:    columns_reg = cfg_data[EXT_W-1:0];
          REG_GRID_ROWS:       rows_reg    = cfg_data[EXT_W-1:0];
          default: ;
        endcase
      end
    end
    queries_in_flight = expected_heights.size();
  end

endmodule

FILE: tb/heightmap_bilinear_sampler_core_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the heightmap sampler; all scoring is done in
// the checker instance, which also reports accepted requests and the
// number of queries still waiting for their result.
module heightmap_bilinear_sampler_core_tb;
  import hbs_pkg::*;

  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 16;      // covers the pipe for trailing writes
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int CYCLE_LIMIT     = 400_000;

  localparam logic signed [WORD_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] ONE_Q16  = 32'sh0001_0000;
  localparam logic signed [WORD_W-1:0] HALF_Q16 = 32'sh0000_8000;

  typedef struct packed {
    logic signed [WORD_W-1:0] org_x;
    logic signed [WORD_W-1:0] org_z;
    logic        [INV_W-1:0]  inv;
    logic        [EXT_W-1:0]  cols;
    logic        [EXT_W-1:0]  rows;
  } grid_setup_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     opcode;
  logic        [IDX_W-1:0]  cell_column;
  logic        [IDX_W-1:0]  cell_row;
  logic signed [WORD_W-1:0] cell_height;
  logic signed [WORD_W-1:0] query_x;
  logic signed [WORD_W-1:0] query_z;
  logic                     done;
  logic signed [WORD_W-1:0] sampled_height;
  logic                     cfg_write;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [WORD_W-1:0]        cfg_data;

  int requests_taken;
  int queries_in_flight;
  int mismatch_count;

  // stimulus-side view of the grid: current setup and which cells hold data
  grid_setup_t setup;
  grid_setup_t unit_grid;
  bit          written_cells [GRID_SIDE*GRID_SIDE];
  int          idle_pct;

  always #1 clk = ~clk;

  heightmap_bilinear_sampler_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .cell_column    (cell_column),
    .cell_row       (cell_row),
    .cell_height    (cell_height),
    .query_x        (query_x),
    .query_z        (query_z),
    .done           (done),
    .sampled_height (sampled_height),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  hbs_height_checker height_check (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .opcode            (opcode),
    .cell_column       (cell_column),
    .cell_row          (cell_row),
    .cell_height       (cell_height),
    .query_x           (query_x),
    .query_z           (query_z),
    .done              (done),
    .sampled_height    (sampled_height),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .requests_taken    (requests_taken),
    .queries_in_flight (queries_in_flight),
    .mismatch_count    (mismatch_count)
  );

  // effective extent: 0 acts as 1, anything past the store saturates
  function automatic int unsigned extent_of(input logic [EXT_W-1:0] r);
    if (r == 0) return 1;
    if (r > GRID_SIDE) return GRID_SIDE;
    return 32'(r);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions that land on the grid in use (a little past either
  // edge too), some extremes and some pure noise.
  function automatic logic signed [WORD_W-1:0] pick_position(
      input logic signed [WORD_W-1:0] org, input logic [INV_W-1:0] inv,
      input int unsigned side);
    longint      span;
    longint      offset;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return $urandom;
    if (roll < 18) begin
      case ($urandom_range(0, 3))
        0:       return MOST_NEG;
        1:       return MOST_POS;
        2:       return org;
        default: return org - 1;
      endcase
    end
    // world length of the grid: side / inverse spacing
    span = (inv == 0) ? (longint'(1) << 20) : (longint'(side) << 32) / longint'(inv);
    if (span > (longint'(1) << 34)) span = longint'(1) << 34;
    span   = span + span / 8 + 2;
    offset = longint'({$urandom, $urandom} % $unsigned(span)) - span / 16;
    return WORD_W'(longint'(org) + offset);
  endfunction

  function automatic grid_setup_t phase_setup(input int p);
    grid_setup_t s;
    s.org_x = $urandom;
    s.org_z = $urandom;
    s.inv   = INV_W'($urandom_range(1, (1 << INV_W) - 1) >> $urandom_range(0, 20));
    s.cols  = EXT_W'($urandom_range(1, 8));
    s.rows  = EXT_W'($urandom_range(1, 8));
    case (p)
      // zero extents act as one vertex; zero reciprocal pins everything to 0
      0: begin s.cols = '0; s.rows = '0; s.inv = '0; end
      // column count past the store saturates; a single row
      1: begin s.cols = '1; s.rows = EXT_W'(1); s.inv = INV_W'(1 << FRAC_W); end
      2: begin s.cols = EXT_W'(1); s.rows = EXT_W'(GRID_SIDE); end
      3: begin
        s.cols  = EXT_W'(GRID_SIDE);
        s.rows  = EXT_W'(2);
        s.inv   = '1;
        s.org_x = MOST_NEG;
      end
      4: begin s.org_x = MOST_POS; s.org_z = MOST_NEG; end
      5: s.inv = INV_W'(1);
      default: ;
    endcase
    return s;
  endfunction

  // One request: random sender gaps (inputs wiggle while start is low),
  // then hold start until the checker has seen the request taken.
  task automatic send_request(input op_t op, input logic [IDX_W-1:0] col,
                              input logic [IDX_W-1:0] row,
                              input logic signed [WORD_W-1:0] height,
                              input logic signed [WORD_W-1:0] qx,
                              input logic signed [WORD_W-1:0] qz);
    int taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start       <= 1'b0;
      opcode      <= 1'($urandom);
      cell_height <= $urandom;
      query_x     <= $urandom;
      @(negedge clk);
    end
    start       <= 1'b1;
    opcode      <= op;
    cell_column <= col;
    cell_row    <= row;
    cell_height <= height;
    query_x     <= qx;
    query_z     <= qz;
    if (op == OP_WRITE) written_cells[{row, col}] = 1'b1;
    taken = requests_taken;
    do @(negedge clk); while (requests_taken == taken);
  endtask

  // Sender holds off until every query has its result, then lets trailing
  // writes run out of the pipe.
  task automatic drain_results();
    start <= 1'b0;
    while (queries_in_flight != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // All five registers, then one write to an unused index that must not
  // disturb anything. Upper data bits of narrow registers are random.
  task automatic program_grid(input grid_setup_t s);
    cfg_write <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= s.org_x;
    @(negedge clk);
    cfg_index <= REG_ORIGIN_Z;
    cfg_data  <= s.org_z;
    @(negedge clk);
    cfg_index <= REG_INVERSE_SPACING;
    cfg_data  <= {8'($urandom), s.inv};
    @(negedge clk);
    cfg_index <= REG_GRID_COLUMNS;
    cfg_data  <= {24'($urandom), s.cols};
    @(negedge clk);
    cfg_index <= REG_GRID_ROWS;
    cfg_data  <= {24'($urandom), s.rows};
    @(negedge clk);
    cfg_index <= CFG_INDEX_W'(REG_GRID_ROWS + $urandom_range(1, 3));
    cfg_data  <= $urandom;
    @(negedge clk);
    cfg_write <= 1'b0;
    setup = s;
  endtask

  // Every vertex the current extent can reach must hold data before any
  // query reads it.
  task automatic cover_extent();
    for (int r = 0; r < extent_of(setup.rows); r++)
      for (int c = 0; c < extent_of(setup.cols); c++)
        if (!written_cells[r * GRID_SIDE + c])
          send_request(OP_WRITE, IDX_W'(c), IDX_W'(r), pick_height(), $urandom, $urandom);
  endtask

  task automatic random_request();
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    if ($urandom_range(0, 99) < 55) begin
      send_request(OP_QUERY, IDX_W'($urandom), IDX_W'($urandom), $urandom,
                   pick_position(setup.org_x, setup.inv, extent_of(setup.cols)),
                   pick_position(setup.org_z, setup.inv, extent_of(setup.rows)));
    end else begin
      // mostly cells in use (overwrites), else anywhere in the store
      if ($urandom_range(0, 99) < 75) begin
        col = IDX_W'($urandom_range(0, extent_of(setup.cols) - 1));
        row = IDX_W'($urandom_range(0, extent_of(setup.rows) - 1));
      end else begin
        col = IDX_W'($urandom);
        row = IDX_W'($urandom);
      end
      send_request(OP_WRITE, col, row, pick_height(), $urandom, $urandom);
    end
  endtask

  // Run limit: a hung pipe or lost result ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: cycle limit reached, %0d queries outstanding", queries_in_flight);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    opcode      = OP_WRITE;
    cell_column = '0;
    cell_row    = '0;
    cell_height = '0;
    query_x     = '0;
    query_z     = '0;
    cfg_write   = 1'b0;
    cfg_index   = REG_ORIGIN_X;
    cfg_data    = '0;
    idle_pct    = 0;
    // reset defaults
    setup.org_x = '0;
    setup.org_z = '0;
    setup.inv   = INV_W'(1 << FRAC_W);
    setup.cols  = EXT_W'(GRID_SIDE);
    setup.rows  = EXT_W'(GRID_SIDE);
    unit_grid       = setup;
    unit_grid.cols  = EXT_W'(2);
    unit_grid.rows  = EXT_W'(2);

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed part, back to back ---
    // empty store: a query reads zero wherever it lands
    send_request(OP_QUERY, '0, '0, '0, '0, '0);
    send_request(OP_QUERY, '1, '1, MOST_POS, MOST_POS, MOST_POS);
    send_request(OP_QUERY, '0, '0, '0, MOST_NEG, MOST_NEG);
    drain_results();

    // 2x2 grid at the origin, unit spacing, extreme corner heights
    program_grid(unit_grid);
    send_request(OP_WRITE, '0, '0, MOST_POS, '0, '0);
    send_request(OP_WRITE, IDX_W'(1), '0, MOST_NEG, '0, '0);
    send_request(OP_WRITE, '0, IDX_W'(1), '0, '0, '0);
    send_request(OP_WRITE, IDX_W'(1), IDX_W'(1), ONE_Q16, '0, '0);
    // beyond the extent in use: stored, not read while this setup holds
    send_request(OP_WRITE, '1, '1, pick_height(), '0, '0);
    // exact vertices, midpoint, both fractions, far-edge and below-origin clamps
    send_request(OP_QUERY, '0, '0, '0, '0, '0);
    send_request(OP_QUERY, '0, '0, '0, HALF_Q16, '0);
    send_request(OP_QUERY, '0, '0, '0, ONE_Q16, ONE_Q16);
    send_request(OP_QUERY, '0, '0, '0, 32'sh0000_4000, 32'sh0000_C000);
    send_request(OP_QUERY, '0, '0, '0, 32'sh0000_FFFF, 32'sh0000_0001);
    send_request(OP_QUERY, '0, '0, '0, MOST_POS, MOST_POS);
    send_request(OP_QUERY, '0, '0, '0, MOST_NEG, MOST_NEG);
    // overwrite then read straight back: query right behind its write
    send_request(OP_WRITE, '0, '0, MOST_NEG, '0, '0);
    send_request(OP_QUERY, '0, '0, '0, '0, HALF_Q16);

    // --- random phases: sender gaps 15%, then 87%, then none ---
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p < PHASES / 3) ? 15 : (p < 2 * PHASES / 3) ? 87 : 0;
      drain_results();
      program_grid(phase_setup(p));
      cover_extent();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_request();
        // occasional full hold-off with no config change
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
